FILE: rtl/core/scp_pkg.sv
`timescale 1ns / 1ps

package scp_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned DutyW  = 8;
  localparam int unsigned ValueW = 10;
  localparam int unsigned UserW  = 2;

  localparam logic [ByteW-1:0]  IdChar    = 8'h33;
  localparam logic [ByteW-1:0]  DigitLo   = 8'd48;
  localparam logic [ByteW-1:0]  DigitHi   = 8'd57;
  localparam logic [ByteW-1:0]  CloseChar = 8'h7d;
  localparam logic [ValueW-1:0] DutyMax   = 10'd255;

  localparam logic [2:0] NameLast = 3'd5;
  localparam logic [2:0] TailLen  = 3'd5;

  typedef struct packed {
    logic [DutyW-1:0] duty_value;
    logic             duty_updated;
    logic             frame_done;
  } scp_result_t;

  function automatic logic [ByteW-1:0] name_letter(input logic [2:0] idx);
    logic [ByteW-1:0] c;
    unique case (idx)
      3'd0:    c = 8'h6d;
      3'd1:    c = 8'h66;
      3'd2:    c = 8'h63;
      3'd3:    c = 8'h72;
      3'd4:    c = 8'h65;
      3'd5:    c = 8'h71;
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic logic [ByteW-1:0] tail_letter(input logic [2:0] idx);
    logic [ByteW-1:0] c;
    unique case (idx)
      3'd0:    c = 8'h63;
      3'd1:    c = 8'h6c;
      3'd2:    c = 8'h72;
      3'd3:    c = 8'h65;
      3'd4:    c = 8'h77;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/core/scp_fsm.sv
`timescale 1ns / 1ps

module scp_fsm (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic [scp_pkg::ByteW-1:0]   rx_byte_i,
  output scp_pkg::scp_result_t        result_o
);

  typedef enum logic [1:0] {
    PhWait   = 2'd0,
    PhName   = 2'd1,
    PhDigits = 2'd2,
    PhTail   = 2'd3
  } phase_e;

  phase_e                       phase_q, phase_d;
  logic [2:0]                   letter_q, letter_d;
  logic [1:0]                   digit_q, digit_d;
  logic [scp_pkg::ValueW-1:0]   value_q, value_d;
  logic [scp_pkg::DutyW-1:0]    duty_q, duty_d;
  logic                         updated;
  logic                         done;
  logic                         is_digit;
  logic [3:0]                   dval;
  logic [scp_pkg::ValueW-1:0]   sum;

  assign is_digit = (rx_byte_i >= scp_pkg::DigitLo) && (rx_byte_i <= scp_pkg::DigitHi);
  assign dval     = 4'(rx_byte_i - scp_pkg::DigitLo);
  assign sum      = value_q + scp_pkg::ValueW'(dval);

  always_comb begin
    phase_d  = phase_q;
    letter_d = letter_q;
    digit_d  = digit_q;
    value_d  = value_q;
    duty_d   = duty_q;
    updated  = 1'b0;
    done     = 1'b0;
    unique case (phase_q)
      PhWait: begin
        if (rx_byte_i == scp_pkg::IdChar) begin
          phase_d  = PhName;
          letter_d = '0;
          digit_d  = '0;
        end
      end
      PhName: begin
        if (letter_q <= scp_pkg::NameLast && rx_byte_i == scp_pkg::name_letter(letter_q)) begin
          if (letter_q == scp_pkg::NameLast) begin
            phase_d  = PhDigits;
            letter_d = '0;
            digit_d  = '0;
          end else begin
            letter_d = letter_q + 3'd1;
          end
        end
      end
      PhDigits: begin
        if (is_digit) begin
          unique case (digit_q)
            2'd0: begin
              value_d = scp_pkg::ValueW'(dval) * scp_pkg::ValueW'(100);
              digit_d = 2'd1;
            end
            2'd1: begin
              value_d = value_q + scp_pkg::ValueW'(dval) * scp_pkg::ValueW'(10);
              digit_d = 2'd2;
            end
            2'd2: begin
              value_d = sum;
              if (sum <= scp_pkg::DutyMax) begin
                duty_d  = sum[scp_pkg::DutyW-1:0];
                updated = 1'b1;
              end
              phase_d = PhTail;
              digit_d = '0;
            end
            default: ;
          endcase
        end
      end
      PhTail: begin
        if (letter_q < scp_pkg::TailLen) begin
          if (rx_byte_i == scp_pkg::tail_letter(letter_q)) begin
            letter_d = letter_q + 3'd1;
          end
        end else if (letter_q == scp_pkg::TailLen) begin
          if (rx_byte_i == scp_pkg::CloseChar) begin
            phase_d  = PhWait;
            letter_d = '0;
            digit_d  = '0;
            done     = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  assign result_o.duty_value   = duty_d;
  assign result_o.duty_updated = updated;
  assign result_o.frame_done   = done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhWait;
      letter_q <= '0;
      digit_q  <= '0;
      value_q  <= '0;
      duty_q   <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      letter_q <= letter_d;
      digit_q  <= digit_d;
      value_q  <= value_d;
      duty_q   <= duty_d;
    end
  end

endmodule

FILE: rtl/core/serial_command_parser.sv
`timescale 1ns / 1ps

// Command recognizer for a received byte stream. Each byte taken on the slave
// side yields exactly one result on the master side, in order. A byte passes
// an input register, then combinational parsing logic into the result
// register, where the master side can take it; the block takes one byte every
// cycle as long as the master side keeps taking results; the parser state
// update between the two registers sets that single-cycle rate.

module serial_command_parser (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [scp_pkg::ByteW-1:0]    s_axis_tdata,   // [7:0] rx_byte
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [scp_pkg::DutyW-1:0]    m_axis_tdata,   // [7:0] duty_value
  output logic [scp_pkg::UserW-1:0]    m_axis_tuser    // [0] duty_updated, [1] frame_done
);

  logic                        in_valid_q;
  logic [scp_pkg::ByteW-1:0]   in_byte_q;
  logic                        out_valid_q;
  scp_pkg::scp_result_t        out_q;
  scp_pkg::scp_result_t        result;
  logic                        out_free;
  logic                        step;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  scp_fsm u_fsm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .rx_byte_i (in_byte_q),
    .result_o  (result)
  );

  // Hold the byte until the parser consumes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_q.duty_value;
  assign m_axis_tuser[0] = out_q.duty_updated;
  assign m_axis_tuser[1] = out_q.frame_done;

endmodule

FILE: rtl/core/scp_checker.sv
`timescale 1ns / 1ps

module scp_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tready,
  input  logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  input  logic [scp_pkg::DutyW-1:0]    m_axis_tdata,
  input  logic [scp_pkg::UserW-1:0]    m_axis_tuser
);

  logic [scp_pkg::DutyW-1:0] last_duty_q;
  logic                      out_xfer;

  assign out_xfer = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_duty_q <= '0;
    end else if (out_xfer) begin
      last_duty_q <= m_axis_tdata;
    end
  end

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("duty update and frame end in one transfer");

  a_duty_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && !m_axis_tuser[0]) |-> (m_axis_tdata == last_duty_q))
    else $error("duty changed without update flag");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

endmodule

bind serial_command_parser scp_checker u_scp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

FILE: sim/serial_command_parser_check.sv
`timescale 1ns / 1ps

module serial_command_parser_check (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  input  logic                      s_axis_tready,
  input  logic [scp_pkg::ByteW-1:0] s_axis_tdata,   // [7:0] rx_byte
  input  logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  input  logic [scp_pkg::DutyW-1:0] m_axis_tdata,   // [7:0] duty_value
  input  logic [scp_pkg::UserW-1:0] m_axis_tuser,   // [0] duty_updated, [1] frame_done
  output int                        mismatch_count_o,
  output int                        pending_o,
  output int                        bytes_seen_o,
  output int                        results_seen_o,
  output int                        duty_writes_o,
  output int                        duty_drops_o,
  output int                        frames_closed_o
);

  import scp_pkg::*;

  typedef enum logic [1:0] {
    ScanId,
    ScanName,
    ScanDigits,
    ScanTail
  } scan_phase_e;

  localparam logic [6*ByteW-1:0] NameSeq = "mfcreq";
  localparam logic [5*ByteW-1:0] TailSeq = "clrew";

  scan_phase_e      phase_q    = ScanId;
  logic [2:0]       letter_idx = '0;
  logic [1:0]       digit_idx  = '0;
  logic [ValueW-1:0] value_acc = '0;
  logic [DutyW-1:0] duty_held  = '0;

  scp_result_t expected_results[$];

  int mismatches    = 0;
  int bytes_seen    = 0;
  int results_seen  = 0;
  int duty_writes   = 0;
  int duty_drops    = 0;
  int frames_closed = 0;

  assign mismatch_count_o = mismatches;
  assign pending_o        = expected_results.size();
  assign bytes_seen_o     = bytes_seen;
  assign results_seen_o   = results_seen;
  assign duty_writes_o    = duty_writes;
  assign duty_drops_o     = duty_drops;
  assign frames_closed_o  = frames_closed;

  task automatic parse_byte(input logic [ByteW-1:0] c, output scp_result_t r);
    logic [ValueW-1:0] d;
    logic              upd;
    logic              done;
    d    = ValueW'(c - DigitLo);
    upd  = 1'b0;
    done = 1'b0;
    case (phase_q)
      ScanId: begin
        if (c == IdChar) begin
          phase_q    = ScanName;
          letter_idx = '0;
          digit_idx  = '0;
        end
      end
      ScanName: begin
        if (letter_idx <= NameLast && c == NameSeq[ByteW*(NameLast-letter_idx) +: ByteW]) begin
          if (letter_idx == NameLast) begin
            phase_q    = ScanDigits;
            letter_idx = '0;
            digit_idx  = '0;
          end else begin
            letter_idx = letter_idx + 3'd1;
          end
        end
      end
      ScanDigits: begin
        if (c >= DigitLo && c <= DigitHi) begin
          if (digit_idx == 2'd0) begin
            value_acc = d * 10'd100;
            digit_idx = 2'd1;
          end else if (digit_idx == 2'd1) begin
            value_acc = value_acc + d * 10'd10;
            digit_idx = 2'd2;
          end else if (digit_idx == 2'd2) begin
            value_acc = value_acc + d;
            if (value_acc <= DutyMax) begin
              duty_held = value_acc[DutyW-1:0];
              upd       = 1'b1;
              duty_writes++;
            end else begin
              duty_drops++;
            end
            phase_q   = ScanTail;
            digit_idx = '0;
          end
        end
      end
      default: begin
        if (letter_idx < TailLen) begin
          if (c == TailSeq[ByteW*(TailLen-1-letter_idx) +: ByteW])
            letter_idx = letter_idx + 3'd1;
        end else if (letter_idx == TailLen) begin
          if (c == CloseChar) begin
            phase_q    = ScanId;
            letter_idx = '0;
            digit_idx  = '0;
            done       = 1'b1;
            frames_closed++;
          end
        end
      end
    endcase
    r.duty_value   = duty_held;
    r.duty_updated = upd;
    r.frame_done   = done;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    scp_result_t exp_r;
    scp_result_t got_r;
    if (!rst_ni) begin
      phase_q    = ScanId;
      letter_idx = '0;
      digit_idx  = '0;
      value_acc  = '0;
      duty_held  = '0;
      expected_results.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        parse_byte(s_axis_tdata, exp_r);
        expected_results.push_back(exp_r);
        bytes_seen++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_r.duty_value   = m_axis_tdata;
        got_r.duty_updated = m_axis_tuser[0];
        got_r.frame_done   = m_axis_tuser[1];
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result duty %0d upd %0b done %0b", $realtime,
                     got_r.duty_value, got_r.duty_updated, got_r.frame_done);
        end else begin
          exp_r = expected_results.pop_front();
          if (got_r !== exp_r) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: result %0d expected duty %0d upd %0b done %0b, got duty %0d upd %0b done %0b",
                       $realtime, results_seen, exp_r.duty_value, exp_r.duty_updated,
                       exp_r.frame_done, got_r.duty_value, got_r.duty_updated,
                       got_r.frame_done);
          end
        end
        results_seen++;
      end
    end
  end

endmodule

FILE: sim/serial_command_parser_test.sv
`timescale 1ns / 1ps

module serial_command_parser_test;

  import scp_pkg::*;

  localparam int DirectedItems = 22;
  localparam int RandomItems   = 450;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [ByteW-1:0]   s_axis_tdata  = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [DutyW-1:0]   m_axis_tdata;
  logic [UserW-1:0]   m_axis_tuser;
  logic               calm          = 1'b0;

  int items_sent = 0;
  int mismatch_count;
  int pending;
  int bytes_seen;
  int results_seen;
  int duty_writes;
  int duty_drops;
  int frames_closed;

  serial_command_parser dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  serial_command_parser_check checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .m_axis_tuser     (m_axis_tuser),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending),
    .bytes_seen_o     (bytes_seen),
    .results_seen_o   (results_seen),
    .duty_writes_o    (duty_writes),
    .duty_drops_o     (duty_drops),
    .frames_closed_o  (frames_closed)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // drop tready at random except in the calm stretch
  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(0, 99) >= 21);
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic send_byte(input logic [ByteW-1:0] b);
    calm <= (items_sent >= 200 && items_sent < 300);
    while (!calm && $urandom_range(0, 99) < 21) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // well-formed frame with random value, stray bytes and an occasional cut
  task automatic send_frame();
    int          pick;
    int          cut;
    logic [9:0]  val;
    string       body;
    pick = $urandom_range(0, 9);
    case (pick)
      0:       val = 10'd0;
      1:       val = 10'd255;
      2:       val = 10'd256;
      3:       val = 10'd999;
      4, 5, 6: val = 10'($urandom_range(0, 255));
      default: val = 10'($urandom_range(0, 999));
    endcase
    body = $sformatf("3mfcreq%03dclrew}", val);
    cut  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, body.len() - 1) : body.len();
    for (int i = 0; i < cut; i++) begin
      if ($urandom_range(0, 7) == 0) send_byte(8'($urandom_range(0, 255)));
      send_byte(body[i]);
    end
  endtask

  task automatic send_noise();
    string alphabet;
    int    n;
    alphabet = "3mfcreqlw}0123456789";
    n = $urandom_range(3, 12);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 1) == 0) send_byte(8'($urandom_range(0, 255)));
      else send_byte(alphabet[$urandom_range(0, alphabet.len() - 1)]);
    end
  endtask

  initial begin
    int waited;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_byte(8'h00);
    send_byte(8'hff);
    send_text("}3xmfcreq/2:56clrew}");

    while (items_sent < DirectedItems + RandomItems) begin
      if ($urandom_range(0, 99) < 80) send_frame();
      else send_noise();
    end
    s_axis_tvalid <= 1'b0;

    waited = 0;
    while (pending != 0 && waited < 2000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (8) @(posedge clk_i);

    $display("Sent %0d bytes, checked %0d results: %0d duty writes, %0d values over 255 dropped,",
             bytes_seen, results_seen, duty_writes, duty_drops);
    $display("%0d frames closed, %0d results still outstanding.", frames_closed, pending);
    if (mismatch_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: serial_command_parser.f
rtl/core/scp_pkg.sv
rtl/core/scp_fsm.sv
rtl/core/serial_command_parser.sv
rtl/core/scp_checker.sv
sim/serial_command_parser_check.sv
sim/serial_command_parser_test.sv
